// File: hdl/b64_pkg.sv
package b64_pkg;

    // Decoder symbol codes beyond the 64 data sextets.
    localparam logic [6:0] SYM_PAD  = 7'd64;
    localparam logic [6:0] SYM_NONE = 7'd65;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // Register indexes on the configuration port.
    localparam logic REG_MODE     = 1'b0;
    localparam logic REG_URL_SAFE = 1'b1;

    localparam int MAX_RES = 4;

    // Mode register values.
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Configuration seen by the codec core.
    typedef struct packed {
        logic mode;
        logic url_safe;
        logic clear_group;
    } b64_cfg_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       message_end;
    } b64_res_t;

    // All results caused by one input transaction.
    typedef struct packed {
        b64_res_t [MAX_RES-1:0] res;
        logic [2:0]             count;
    } b64_set_t;

    // Sextet to alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] v, input logic url);
        logic [7:0] c;
        begin
            if (v < 6'd26)
                c = 8'h41 + {2'b00, v};
            else if (v < 6'd52)
                c = 8'h61 + {2'b00, v} - 8'd26;
            else if (v < 6'd62)
                c = 8'h30 + {2'b00, v} - 8'd52;
            else if (v == 6'd62)
                c = url ? 8'h2D : 8'h2B;
            else
                c = url ? 8'h5F : 8'h2F;
            return c;
        end
    endfunction

    // Character to sextet; both alphabets accepted.
    function automatic logic [6:0] dec_sym(input logic [7:0] c);
        logic [6:0] s;
        begin
            if (c >= 8'h41 && c <= 8'h5A)
                s = 7'(c - 8'h41);
            else if (c >= 8'h61 && c <= 8'h7A)
                s = 7'(c - 8'h61 + 8'd26);
            else if (c >= 8'h30 && c <= 8'h39)
                s = 7'(c - 8'h30 + 8'd52);
            else if (c == 8'h2B || c == 8'h2D)
                s = 7'd62;
            else if (c == 8'h2F || c == 8'h5F)
                s = 7'd63;
            else if (c == CHAR_PAD)
                s = SYM_PAD;
            else
                s = SYM_NONE;
            return s;
        end
    endfunction

endpackage

// File: hdl/b64_if.sv
// Input channel: one byte or character per transaction.
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       msg_last;

    modport source (output valid, output in_byte, output msg_last, input ready);
    modport sink (input valid, input in_byte, input msg_last, output ready);
endinterface

// Output channel: one result per transaction.
interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_end;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output message_end, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input run_last,
                  input message_end, output ready);
endinterface

// File: hdl/b64_cfg.sv
module b64_cfg
    import b64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output b64_cfg_t    cfg
);

    logic mode_reg;
    logic url_safe_reg;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ENCODE;
            url_safe_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_MODE)
                mode_reg <= pwdata[0];
            else
                url_safe_reg <= pwdata[0];
        end
    end

    // Read back.
    assign prdata = {31'd0, (reg_sel == REG_MODE) ? mode_reg : url_safe_reg};

    // A mode write abandons any partial group.
    assign cfg.mode        = mode_reg;
    assign cfg.url_safe    = url_safe_reg;
    assign cfg.clear_group = wr_en && (reg_sel == REG_MODE);

endmodule

// File: hdl/b64_core.sv
module b64_core
    import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  b64_cfg_t   cfg,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       msg_last,
    output b64_set_t   set
);

    logic [23:0] group_bits_reg, group_bits_next;
    logic [1:0]  group_count_reg, group_count_next;
    logic [1:0]  pad_marks_reg, pad_marks_next;

    logic [23:0] bits;
    logic [1:0]  enc_n;
    logic [2:0]  enc_n1;
    logic        enc_emit;
    logic [6:0]  sym;
    logic [5:0]  sext;
    logic        sym_ok;
    logic        sym_pad;
    logic [1:0]  pad_new;
    logic [1:0]  cnt_new;
    logic        full_grp;
    logic [1:0]  nb_full;
    logic [1:0]  nb_tail;
    logic [1:0]  nb_each;
    logic [2:0]  k;
    b64_res_t [MAX_RES-1:0] res;

    always_comb
    begin
        bits             = group_bits_reg;
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        pad_marks_next   = pad_marks_reg;
        enc_n            = (group_count_reg == 2'd3) ? 2'd2 : group_count_reg;
        enc_n1           = {1'b0, enc_n} + 3'd1;
        enc_emit         = 1'b0;
        sym              = dec_sym(in_byte);
        sext             = sym[5:0];
        sym_ok           = (sym != SYM_NONE);
        sym_pad          = (sym == SYM_PAD);
        pad_new          = pad_marks_reg;
        cnt_new          = group_count_reg;
        full_grp         = 1'b0;
        nb_full          = 2'd0;
        nb_tail          = 2'd0;
        nb_each          = 2'd0;
        k                = 3'd0;
        res              = '0;

        if (cfg.mode == MODE_ENCODE)
        begin
            // Pack the byte into the group and emit four characters when done.
            unique case (enc_n)
                2'd0:    bits[23:16] = bits[23:16] | in_byte;
                2'd1:    bits[15:8]  = bits[15:8] | in_byte;
                default: bits[7:0]   = bits[7:0] | in_byte;
            endcase
            enc_emit = (enc_n1 == 3'd3) || msg_last;
            res[0].out_byte   = enc_char(bits[23:18], cfg.url_safe);
            res[1].out_byte   = enc_char(bits[17:12], cfg.url_safe);
            res[2].out_byte   = (enc_n1 >= 3'd2) ? enc_char(bits[11:6], cfg.url_safe)
                                                 : CHAR_PAD;
            res[3].out_byte   = (enc_n1 >= 3'd3) ? enc_char(bits[5:0], cfg.url_safe)
                                                 : CHAR_PAD;
            res[0].byte_valid = 1'b1;
            res[1].byte_valid = 1'b1;
            res[2].byte_valid = 1'b1;
            res[3].byte_valid = 1'b1;
            if (enc_emit)
            begin
                k                = 3'd4;
                group_bits_next  = '0;
                group_count_next = '0;
                pad_marks_next   = '0;
            end
            else
            begin
                group_bits_next  = bits;
                group_count_next = enc_n1[1:0];
            end
        end
        else
        begin
            // Place a recognized sextet; padding counts as a zero sextet.
            if (sym_ok)
            begin
                if (sym_pad)
                    sext = 6'd0;
                unique case (group_count_reg)
                    2'd0:    bits[23:18] = bits[23:18] | sext;
                    2'd1:    bits[17:12] = bits[17:12] | sext;
                    2'd2:    bits[11:6]  = bits[11:6] | sext;
                    default: bits[5:0]   = bits[5:0] | sext;
                endcase
                if (sym_pad && pad_marks_reg != 2'd3)
                    pad_new = pad_marks_reg + 2'd1;
                if (group_count_reg == 2'd3)
                    full_grp = 1'b1;
                else
                    cnt_new = group_count_reg + 2'd1;
            end

            // Bytes from a completed group.
            if (pad_new == 2'd0)
                nb_full = 2'd3;
            else if (pad_new == 2'd1 && sym_pad)
                nb_full = 2'd2;
            else
                nb_full = 2'd1;

            // Bytes from an unpadded tail at message end.
            if (cnt_new >= 2'd2)
                nb_tail = (pad_new >= cnt_new - 2'd1) ? 2'd0 : cnt_new - 2'd1 - pad_new;

            if (full_grp)
                nb_each = nb_full;
            else if (msg_last)
                nb_each = nb_tail;

            res[0].out_byte   = bits[23:16];
            res[1].out_byte   = bits[15:8];
            res[2].out_byte   = bits[7:0];
            res[0].byte_valid = 1'b1;
            res[1].byte_valid = 1'b1;
            res[2].byte_valid = 1'b1;
            k = {1'b0, nb_each};

            if (full_grp || msg_last)
            begin
                group_bits_next  = '0;
                group_count_next = '0;
                pad_marks_next   = '0;
            end
            else
            begin
                group_bits_next  = bits;
                group_count_next = cnt_new;
                pad_marks_next   = pad_new;
            end
        end

        // A message end with no data gives one bare end marker.
        if (msg_last && k == 3'd0)
        begin
            res[0] = '0;
            k      = 3'd1;
        end

        // Flag the last result of this transaction.
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (k == 3'(i + 1))
            begin
                res[i].run_last    = 1'b1;
                res[i].message_end = msg_last;
            end
        end
    end

    assign set.res   = res;
    assign set.count = k;

    // Group state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            pad_marks_reg   <= '0;
        end
        else if (cfg.clear_group)
        begin
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            pad_marks_reg   <= '0;
        end
        else if (accept)
        begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
            pad_marks_reg   <= pad_marks_next;
        end
    end

endmodule

// File: hdl/b64_outq.sv
module b64_outq
    import b64_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  b64_set_t set,
    output logic     load_ok,
    b64_out_if.source dout
);

    b64_res_t [MAX_RES-1:0] slot_reg, slot_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic                   pop;

    assign pop     = dout.valid && dout.ready;
    assign load_ok = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && dout.ready);

    // Load a fresh result set or shift out the head.
    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            slot_next = set.res;
            cnt_next  = set.count;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    assign dout.valid       = (cnt_reg != 3'd0);
    assign dout.out_byte    = slot_reg[0].out_byte;
    assign dout.byte_valid  = slot_reg[0].byte_valid;
    assign dout.run_last    = slot_reg[0].run_last;
    assign dout.message_end = slot_reg[0].message_end;

endmodule

// File: hdl/base64_stream_codec.sv
// Base64 stream codec (standard and URL-safe alphabets). With mode 0 it takes
// data bytes and returns four characters per three bytes, padding the last
// group with '=' at a message end; with mode 1 it takes characters of either
// alphabet, skips anything else, and returns up to three bytes per group.
// Every message end yields a result flagged message_end (a bare marker with
// byte_valid low when no data is left). The codec computes all results of an
// input transaction in the cycle it is accepted and holds them in a four-entry
// result buffer that drains one result transaction per cycle while the
// receiver is ready. A new input is taken once the buffer is empty or its last
// result leaves in the same cycle. An input that produces at most one result
// therefore is not held for its own result; otherwise the input is held until
// its last result leaves. When encoding, the first two bytes of a group give no
// results unless they end the message, and the third holds the input while its
// four characters drain through the single output port. Write mode and url_safe
// only while the codec is idle; writing mode discards any partial group.
module base64_stream_codec
    import b64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    b64_in_if.sink      din,
    b64_out_if.source   dout,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    b64_cfg_t cfg;
    b64_set_t set;
    logic     load_ok;
    logic     accept;

    assign din.ready = load_ok;
    assign accept    = din.valid && load_ok;

    b64_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    b64_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .in_byte  (din.in_byte),
        .msg_last (din.msg_last),
        .set      (set)
    );

    b64_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .set     (set),
        .load_ok (load_ok),
        .dout    (dout)
    );

endmodule

// File: tb/tb_base64_stream_codec.sv
`timescale 1ns / 1ps

module tb_base64_stream_codec
    import b64_pkg::*;
();

    // Shadow copy of the codec. It tracks registers and group state, turns every
    // accepted input transaction into the results it must cause, and matches
    // them in order against the result transactions that come out.
    class codec_shadow;
        logic       mode_q;
        logic       url_q;
        logic [23:0] grp_bits;
        int         grp_cnt;
        int         pads;
        int         fails;
        b64_res_t   step_run[$];
        b64_res_t   coded_out_q[$];

        function new();
            mode_q = MODE_ENCODE;
            url_q = 1'b1;
            fails = 0;
            clear_group();
        endfunction

        function void clear_group();
            grp_bits = '0;
            grp_cnt = 0;
            pads = 0;
        endfunction

        function void write_reg(logic idx, logic val);
            if (idx == REG_MODE)
            begin
                mode_q = val;
                clear_group();
            end
            else
            begin
                url_q = val;
            end
        endfunction

        static function logic [7:0] sextet_to_char(logic [5:0] v, logic url_alpha);
            logic [7:0] c;
            if (v <= 6'd25)
                c = 8'h41 + 8'(v);
            else if (v <= 6'd51)
                c = 8'h61 + 8'(v - 6'd26);
            else if (v <= 6'd61)
                c = 8'h30 + 8'(v - 6'd52);
            else if (v == 6'd62)
                c = url_alpha ? 8'h2D : 8'h2B;
            else
                c = url_alpha ? 8'h5F : 8'h2F;
            return c;
        endfunction

        static function logic [6:0] char_to_sextet(logic [7:0] c);
            logic [6:0] s;
            s = SYM_NONE;
            if (c >= 8'h41 && c <= 8'h5A)
                s = 7'(c - 8'h41);
            else if (c >= 8'h61 && c <= 8'h7A)
                s = 7'(c - 8'h61) + 7'd26;
            else if (c >= 8'h30 && c <= 8'h39)
                s = 7'(c - 8'h30) + 7'd52;
            else if (c == 8'h2B || c == 8'h2D)
                s = 7'd62;
            else if (c == 8'h2F || c == 8'h5F)
                s = 7'd63;
            else if (c == CHAR_PAD)
                s = SYM_PAD;
            return s;
        endfunction

        function void emit(logic [7:0] b, logic vld);
            b64_res_t r;
            r.out_byte = b;
            r.byte_valid = vld;
            r.run_last = 1'b0;
            r.message_end = 1'b0;
            step_run.push_back(r);
        endfunction

        // Decoded bytes come out of the group from the top byte down.
        function void emit_bytes(int nb);
            for (int i = 0; i < nb && i < 3; i++)
                emit(grp_bits[23 - 8 * i -: 8], 1'b1);
        endfunction

        // Notes one accepted input transaction and queues the results it causes.
        function void absorb_byte(logic [7:0] b, logic last);
            int         n;
            int         nb;
            logic [6:0] sym;
            logic [5:0] v;
            step_run.delete();
            if (mode_q == MODE_ENCODE)
            begin
                n = (grp_cnt > 2) ? 2 : grp_cnt;
                grp_bits = grp_bits | (24'(b) << (16 - 8 * n));
                n++;
                if (n == 3 || last)
                begin
                    emit(sextet_to_char(grp_bits[23:18], url_q), 1'b1);
                    emit(sextet_to_char(grp_bits[17:12], url_q), 1'b1);
                    emit((n >= 2) ? sextet_to_char(grp_bits[11:6], url_q) : CHAR_PAD, 1'b1);
                    emit((n >= 3) ? sextet_to_char(grp_bits[5:0], url_q) : CHAR_PAD, 1'b1);
                    clear_group();
                end
                else
                begin
                    grp_cnt = n;
                end
            end
            else
            begin
                sym = char_to_sextet(b);
                if (sym != SYM_NONE)
                begin
                    n = grp_cnt;
                    v = (sym == SYM_PAD) ? 6'd0 : sym[5:0];
                    grp_bits = grp_bits | (24'(v) << (18 - 6 * n));
                    if (sym == SYM_PAD && pads < 3)
                        pads++;
                    if (n == 3)
                    begin
                        // A lone pad in the fourth position leaves two bytes.
                        if (pads == 0)
                            nb = 3;
                        else if (pads == 1 && sym == SYM_PAD)
                            nb = 2;
                        else
                            nb = 1;
                        emit_bytes(nb);
                        clear_group();
                    end
                    else
                    begin
                        grp_cnt = n + 1;
                    end
                end
                // An unfinished tail at the message end gives what it can.
                if (last)
                begin
                    n = grp_cnt;
                    if (n >= 2)
                    begin
                        nb = n - 1;
                        nb = (pads >= nb) ? 0 : nb - pads;
                        emit_bytes(nb);
                    end
                    clear_group();
                end
            end
            if (last && step_run.size() == 0)
                emit(8'h00, 1'b0);
            if (step_run.size() > 0)
            begin
                step_run[step_run.size() - 1].run_last = 1'b1;
                step_run[step_run.size() - 1].message_end = last;
            end
            foreach (step_run[i])
                coded_out_q.push_back(step_run[i]);
        endfunction

        // Matches one result transaction against the oldest queued result.
        function void compare_result(b64_res_t got);
            b64_res_t want;
            if (coded_out_q.size() == 0)
            begin
                $error("unexpected result: out_byte %h byte_valid %b", got.out_byte,
                       got.byte_valid);
                fails++;
                return;
            end
            want = coded_out_q.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                fails++;
            end
            if (got.byte_valid !== want.byte_valid)
            begin
                $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
                fails++;
            end
            if (got.run_last !== want.run_last)
            begin
                $error("run_last: expected %b, got %b", want.run_last, got.run_last);
                fails++;
            end
            if (got.message_end !== want.message_end)
            begin
                $error("message_end: expected %b, got %b", want.message_end, got.message_end);
                fails++;
            end
        endfunction

        function int pending();
            return coded_out_q.size();
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          PHASE_ITEMS = 25;
    localparam int          HOLD_CYCLES = 120;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    b64_in_if  din_ch ();
    b64_out_if dout_ch ();

    codec_shadow tracker;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    int          useful_items = 0;
    int unsigned cycle_cnt = 0;
    b64_res_t    seen_res;

    base64_stream_codec u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_ch),
        .dout    (dout_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_base64_stream_codec NOT OK");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        dout_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                dout_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                dout_ch.ready = no_idle || ($urandom_range(99) >= 14);
            end
        end
    end

    // Every result transaction is checked at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && dout_ch.valid && dout_ch.ready)
        begin
            seen_res.out_byte = dout_ch.out_byte;
            seen_res.byte_valid = dout_ch.byte_valid;
            seen_res.run_last = dout_ch.run_last;
            seen_res.message_end = dout_ch.message_end;
            tracker.compare_result(seen_res);
        end
    end

    // Offers one input transaction and waits until the codec takes it.
    task automatic send_item(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 14)
        begin
            din_ch.valid = 1'b0;
            @(negedge clk);
        end
        din_ch.valid = 1'b1;
        din_ch.in_byte = b;
        din_ch.msg_last = last;
        do
            @(posedge clk);
        while (!din_ch.ready);
        tracker.absorb_byte(b, last);
        if (tracker.mode_q == MODE_ENCODE || codec_shadow::char_to_sextet(b) != SYM_NONE)
            useful_items++;
    endtask

    task automatic send_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], last && (i == s.len() - 1));
    endtask

    // Lowers valid, then lets every queued result drain before going idle.
    task automatic wait_drained();
        @(negedge clk);
        din_ch.valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {31'd0, val};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.write_reg(idx, val);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic logic [7:0] rand_text_char();
        return codec_shadow::sextet_to_char(6'($urandom_range(63)), 1'($urandom_range(1)));
    endfunction

    function automatic logic [7:0] rand_junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (codec_shadow::char_to_sextet(c) != SYM_NONE);
        return c;
    endfunction

    // Raw bytes for the encoder; an unclosed message runs into the next one.
    task automatic send_plain_msg(input bit close);
        int len;
        len = $urandom_range(9, 1);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(255)), close && (i == len - 1));
    endtask

    // Mostly well-formed Base64 text with some junk and stray pads mixed in.
    task automatic send_text_msg(input bit close);
        logic [7:0] chars[$];
        int         groups;
        int         tail;
        int         cnt;
        groups = $urandom_range(3);
        tail = $urandom_range(6);
        repeat (4 * groups) chars.push_back(rand_text_char());
        case (tail)
            1:
            begin
                repeat (2) chars.push_back(rand_text_char());
                repeat (2) chars.push_back(CHAR_PAD);
            end
            2:
            begin
                repeat (3) chars.push_back(rand_text_char());
                chars.push_back(CHAR_PAD);
            end
            3: repeat (2) chars.push_back(rand_text_char());
            4: repeat (3) chars.push_back(rand_text_char());
            5: chars.push_back(rand_text_char());
            6:
            begin
                cnt = $urandom_range(4, 1);
                repeat (cnt)
                begin
                    case ($urandom_range(2))
                        0: chars.push_back(rand_text_char());
                        1: chars.push_back(CHAR_PAD);
                        default: chars.push_back(rand_junk_char());
                    endcase
                end
            end
            default: ;
        endcase
        if (chars.size() == 0)
            chars.push_back(rand_junk_char());
        for (int i = 0; i < chars.size(); i++)
        begin
            if ($urandom_range(99) < 8)
                send_item(rand_junk_char(), 1'b0);
            send_item(chars[i], close && (i == chars.size() - 1));
        end
    endtask

    initial
    begin
        logic phase_mode;
        int   phase_start;
        tracker = new();
        rst_n = 1'b0;
        din_ch.valid = 1'b0;
        din_ch.in_byte = 8'h00;
        din_ch.msg_last = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Encoder with the URL-safe alphabet: sextets 62 and 63, then both
        // padded tails.
        apb_write(REG_MODE, MODE_ENCODE);
        apb_write(REG_URL_SAFE, 1'b1);
        send_item(8'hFB, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h80, 1'b1);
        wait_drained();

        // Encoder with the standard alphabet.
        apb_write(REG_URL_SAFE, 1'b0);
        send_item(8'hFB, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b1);
        wait_drained();

        // Decoder: a pad in the fourth place, pads elsewhere, both alphabets'
        // symbols 62 and 63, and a skipped last character over a short tail.
        apb_write(REG_MODE, MODE_DECODE);
        send_text("QUI=", 1'b0);
        send_text("Q=Q=", 1'b0);
        send_text("+-/_", 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'hFF, 1'b1);
        wait_drained();

        // Random phases. The last phase keeps the decoder mode, so a partial
        // group survives a url_safe write across the phase boundary.
        for (int ph = 0; ph < 8; ph++)
        begin
            phase_mode = (ph == 6) ? MODE_DECODE : ((ph % 2 == 1) ? MODE_DECODE : MODE_ENCODE);
            wait_drained();
            apb_write(REG_URL_SAFE, (ph < 4) ? 1'((ph >> 1) & 1) : 1'($urandom_range(1)));
            if (phase_mode != tracker.mode_q || ph == 0)
                apb_write(REG_MODE, phase_mode);
            no_idle = (ph == 2);
            if (ph == 4)
                hold_req = 1'b1;
            phase_start = useful_items;
            while (useful_items - phase_start < PHASE_ITEMS)
            begin
                if (phase_mode == MODE_ENCODE)
                    send_plain_msg($urandom_range(9) != 0);
                else
                    send_text_msg($urandom_range(9) != 0);
            end
        end

        wait_drained();
        no_idle = 1'b0;
        repeat (12) @(posedge clk);
        if (tracker.fails == 0 && tracker.pending() == 0)
        begin
            $display("tb_base64_stream_codec OK");
        end
        else
        begin
            $display("tb_base64_stream_codec NOT OK");
        end
        $finish;
    end

endmodule
